FILE: sv/shared_exclusive_lock_queue_unit_defines.svh
// Assertion macros for the shared/exclusive lock queue unit.
// Used by the checker; no other dependencies.
`ifndef SHARED_EXCLUSIVE_LOCK_QUEUE_UNIT_DEFINES_SVH
`define SHARED_EXCLUSIVE_LOCK_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication
`define SELQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("selq check failed");

// next-cycle implication
`define SELQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("selq check failed");

`endif

FILE: sv/selq_pkg.sv
// Types and codes for the shared/exclusive lock queue unit.
// No dependencies.
`default_nettype none
package selq_pkg;

   localparam int KEY_W = 32;

   localparam logic [1:0] ACT_ACQ_SH = 2'd0;
   localparam logic [1:0] ACT_ACQ_EX = 2'd1;
   localparam logic [1:0] ACT_REL_SH = 2'd2;
   localparam logic [1:0] ACT_REL_EX = 2'd3;

   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_SH   = 2'd1;
   localparam logic [1:0] MODE_EX   = 2'd2;

   localparam logic [2:0] OUT_GRANTED   = 3'd0;
   localparam logic [2:0] OUT_REFUSED   = 3'd1;
   localparam logic [2:0] OUT_QUEUED    = 3'd2;
   localparam logic [2:0] OUT_RELEASED  = 3'd3;
   localparam logic [2:0] OUT_HANDED    = 3'd4;
   localparam logic [2:0] OUT_NOT_OWNER = 3'd5;
   localparam logic [2:0] OUT_FULL      = 3'd6;

   typedef struct packed {
      logic [1:0]  action;
      logic        wait_mode;
      logic [15:0] txn_id;
      logic [15:0] item_tag;
   } req_type;

   typedef struct packed {
      logic [2:0]  outcome;
      logic [15:0] out_txn_id;
      logic [15:0] out_item_tag;
      logic [1:0]  granted_type;
      logic [1:0]  lock_state;
      logic [4:0]  holder_count;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic             add_en;
      logic             rel_en;
      logic [KEY_W-1:0] key;
   } cell_ctl_type;

endpackage
`default_nettype wire

FILE: sv/selq_owner_cell.sv
// One owner slot of the lock; slots form a priority chain for free and match search.
// Depends on selq_pkg.
`default_nettype none
module selq_owner_cell (
   input  wire                        clock,
   input  wire                        reset,
   input  selq_pkg::cell_ctl_type     ctl,
   input  wire                        free_in,
   input  wire                        hit_in,
   output logic                       free_out,
   output logic                       hit_out
);
   import selq_pkg::*;

   logic             valid_ff, valid_in;
   logic [KEY_W-1:0] entry_ff, entry_in;
   logic             is_free, is_hit, take, drop;

   always_comb begin
      is_free  = ~valid_ff;
      is_hit   = valid_ff & (entry_ff == ctl.key);
      take     = ctl.add_en & ~free_in & is_free;
      drop     = ctl.rel_en & ~hit_in & is_hit;
      free_out = free_in | is_free;
      hit_out  = hit_in | is_hit;
      valid_in = take ? 1'b1 : (drop ? 1'b0 : valid_ff);
      entry_in = take ? ctl.key : entry_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
`default_nettype wire

FILE: sv/shared_exclusive_lock_queue_unit.sv
// Shared/exclusive record lock with a FIFO wait queue: owner cell chain and control.
// Depends on selq_pkg and selq_owner_cell.
//
// Usage:
//  - Requests: drive req_payload and raise start; the request transfers on a
//    clock edge with start high and busy low.
//  - Results: each result shows on rsp_payload for one cycle with rsp_valid
//    high; rsp_payload.last marks the final result of a request. The
//    receiver cannot stall.
//  - csr_write_en/csr_write_data write fair_queue; write only while idle.
//  - Sequence: a request is executed in ST_EXEC and its response is then
//    registered onto rsp_payload. The first handover grant passes ST_HWAIT,
//    ST_HGRANT, ST_HWAIT2 and ST_HDEC before it is registered out; each
//    further one repeats ST_HWAIT2 and ST_HDEC, set by the registered read
//    of the wait queue memory. A new request is taken only back in ST_IDLE;
//    one request at a time.
//  - Owner search and insert use the ripple chain across the owner cells.
//  - Synchronous reset frees the lock, empties the queue and clears
//    fair_queue; no clearing pass is needed.
`default_nettype none
module shared_exclusive_lock_queue_unit #(
   parameter int MAX_OWNERS = 16,
   parameter int WAIT_DEPTH = 16,
   parameter int TXN_BITS   = 16
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  selq_pkg::req_type   req_payload,
   output logic                rsp_valid,
   output selq_pkg::rsp_type   rsp_payload,
   input  wire                 csr_write_en,
   input  wire                 csr_write_data
);
   import selq_pkg::*;

   localparam int OCW  = $clog2(MAX_OWNERS + 1);
   localparam int WCW  = $clog2(WAIT_DEPTH + 1);
   localparam int QW   = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int KEEP = (TXN_BITS < 16) ? TXN_BITS : 16;
   localparam logic [15:0] TXN_MASK = 16'((32'd1 << KEEP) - 32'd1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXEC   = 3'd1;
   localparam logic [2:0] ST_HWAIT  = 3'd2;
   localparam logic [2:0] ST_HGRANT = 3'd3;
   localparam logic [2:0] ST_HWAIT2 = 3'd4;
   localparam logic [2:0] ST_HDEC   = 3'd5;

   logic [2:0]     state_ff, state_in;
   logic           fair_ff;
   req_type        req_ff;
   logic [1:0]     held_ff, held_in;
   logic [OCW-1:0] total_ff, total_in;
   logic [QW-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [WCW-1:0] wtotal_ff, wtotal_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in, pend_ff, pend_in;

   logic [KEY_W:0] wq_mem [WAIT_DEPTH];
   logic [KEY_W:0] wq_rd_ff;
   logic           wq_we;

   cell_ctl_type        ctl;
   logic [MAX_OWNERS:0] free_chain, hit_chain;

   logic [15:0]      req_txn;
   logic [KEY_W-1:0] req_key;
   logic [1:0]       req_kind, w_kind;
   logic             is_acq, conflict, found, more, next_ok, do_hand;
   logic [2:0]       outcome;

   assign free_chain[0] = 1'b0;
   assign hit_chain[0]  = 1'b0;

   for (genvar i = 0; i < MAX_OWNERS; i++) begin : g_cell
      selq_owner_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .free_in  (free_chain[i]),
         .hit_in   (hit_chain[i]),
         .free_out (free_chain[i+1]),
         .hit_out  (hit_chain[i+1])
      );
   end

   function automatic logic [QW-1:0] ptr_next(input logic [QW-1:0] p);
      return (p == QW'(WAIT_DEPTH - 1)) ? '0 : QW'(p + 1'b1);
   endfunction

   always_comb begin
      req_txn  = req_ff.txn_id & TXN_MASK;
      req_key  = {req_txn, req_ff.item_tag};
      req_kind = (req_ff.action == ACT_ACQ_EX || req_ff.action == ACT_REL_EX)
                 ? MODE_EX : MODE_SH;
      is_acq   = (req_ff.action == ACT_ACQ_SH || req_ff.action == ACT_ACQ_EX);
      w_kind   = wq_rd_ff[KEY_W] ? MODE_EX : MODE_SH;

      state_in     = state_ff;
      held_in      = held_ff;
      total_in     = total_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      wtotal_in    = wtotal_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      pend_in      = pend_ff;
      wq_we        = 1'b0;
      ctl.add_en   = 1'b0;
      ctl.rel_en   = 1'b0;
      ctl.key      = (state_ff == ST_EXEC) ? req_key : wq_rd_ff[KEY_W-1:0];
      conflict     = 1'b0;
      found        = 1'b0;
      more         = 1'b0;
      next_ok      = 1'b0;
      do_hand      = 1'b0;
      outcome      = OUT_NOT_OWNER;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (is_acq) begin
               conflict = (req_kind == MODE_SH) ? (held_ff == MODE_EX)
                                                : (held_ff != MODE_NONE);
               if (req_ff.wait_mode && fair_ff && wtotal_ff != '0) conflict = 1'b1;
               if (!conflict) begin
                  if (free_chain[MAX_OWNERS]) begin
                     ctl.add_en = 1'b1;
                     held_in    = req_kind;
                     total_in   = OCW'(total_ff + 1'b1);
                     outcome    = OUT_GRANTED;
                  end else begin
                     outcome = OUT_FULL;
                  end
               end else if (!req_ff.wait_mode) begin
                  outcome = OUT_REFUSED;
               end else if (wtotal_ff >= WCW'(WAIT_DEPTH)) begin
                  outcome = OUT_FULL;
               end else begin
                  wq_we     = 1'b1;
                  tail_in   = ptr_next(tail_ff);
                  wtotal_in = WCW'(wtotal_ff + 1'b1);
                  outcome   = OUT_QUEUED;
               end
            end else begin
               found = hit_chain[MAX_OWNERS] && (held_ff == req_kind);
               if (found) begin
                  ctl.rel_en = 1'b1;
                  total_in   = OCW'(total_ff - 1'b1);
                  if (total_in == '0) held_in = MODE_NONE;
                  outcome = OUT_RELEASED;
                  more    = (total_in == '0) && (wtotal_ff != '0);
               end
            end
            rsp_valid_in = 1'b1;
            rsp_in = '{outcome, req_txn, req_ff.item_tag, req_kind, held_in,
                       5'(total_in), !more};
            state_in = more ? ST_HWAIT : ST_IDLE;
         end
         ST_HWAIT: begin
            state_in = ST_HGRANT;
         end
         ST_HGRANT: begin
            do_hand  = 1'b1;
            state_in = ST_HWAIT2;
         end
         ST_HWAIT2: begin
            state_in = ST_HDEC;
         end
         ST_HDEC: begin
            next_ok = (wtotal_ff != '0) && (pend_ff.granted_type == MODE_SH) &&
                      (w_kind == MODE_SH) && free_chain[MAX_OWNERS];
            rsp_valid_in = 1'b1;
            rsp_in       = pend_ff;
            rsp_in.last  = !next_ok;
            do_hand      = next_ok;
            state_in     = next_ok ? ST_HWAIT2 : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (do_hand) begin
         ctl.add_en = 1'b1;
         held_in    = w_kind;
         total_in   = OCW'(total_ff + 1'b1);
         head_in    = ptr_next(head_ff);
         wtotal_in  = WCW'(wtotal_ff - 1'b1);
         pend_in = '{OUT_HANDED, wq_rd_ff[KEY_W-1:16], wq_rd_ff[15:0], w_kind,
                     w_kind, 5'(total_in), 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fair_ff      <= 1'b0;
         held_ff      <= MODE_NONE;
         total_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         wtotal_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         total_ff     <= total_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         wtotal_ff    <= wtotal_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) fair_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) req_ff <= req_payload;
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
   end

   always_ff @(posedge clock) begin
      if (wq_we) wq_mem[tail_ff] <= {(req_kind == MODE_EX), req_key};
      wq_rd_ff <= wq_mem[head_ff];
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

FILE: sv/selq_checker.sv
// Port-level checks for the shared/exclusive lock queue unit, bound to the top level.
// Depends on selq_pkg and shared_exclusive_lock_queue_unit_defines.svh.
`default_nettype none
`include "shared_exclusive_lock_queue_unit_defines.svh"
module selq_port_checker (
   input wire                clock,
   input wire                reset,
   input wire                start,
   input wire                busy,
   input wire                rsp_valid,
   input selq_pkg::rsp_type  rsp_payload
);
   import selq_pkg::*;

   `SELQ_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `SELQ_ASSERT_NEXT(a_accept_gap, clock, reset, start && !busy, !rsp_valid)
   `SELQ_ASSERT_NEXT(a_last_gap, clock, reset, rsp_valid && rsp_payload.last, !rsp_valid)
   `SELQ_ASSERT_NOW(a_refused_last, clock, reset,
      rsp_valid && rsp_payload.outcome == OUT_REFUSED, rsp_payload.last)

endmodule

bind shared_exclusive_lock_queue_unit selq_port_checker u_selq_checker (.*);
`default_nettype wire
